// ===== rtl/l3d_pkg.sv =====
// Shared types for the 3D line point generator.
// No dependencies; used by l3d_axis_diff, line_point_generator_3d_unit and line_voxel_checker.
`default_nettype none

package l3d_pkg;

	// axis codes, also the index into per-axis registers
	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

endpackage

`default_nettype wire

// ===== rtl/l3d_axis_diff.sv =====
// Shared absolute-difference unit: one axis per cycle, chosen by sel.
// Depends on l3d_pkg (axis_t).
`default_nettype none

module l3d_axis_diff #(
	parameter int COORD_BITS = 6
) (
	input  wire [2:0][COORD_BITS-1:0] a_coords,
	input  wire [2:0][COORD_BITS-1:0] b_coords,
	input  l3d_pkg::axis_t            sel,
	output logic [COORD_BITS-1:0]     abs_diff,
	output logic                      neg
);

	logic [COORD_BITS-1:0] a_sel;
	logic [COORD_BITS-1:0] b_sel;
	logic [COORD_BITS:0]   diff;

	always_comb begin
		case (sel)
			l3d_pkg::AXIS_X: begin
				a_sel = a_coords[0];
				b_sel = b_coords[0];
			end
			l3d_pkg::AXIS_Y: begin
				a_sel = a_coords[1];
				b_sel = b_coords[1];
			end
			l3d_pkg::AXIS_Z: begin
				a_sel = a_coords[2];
				b_sel = b_coords[2];
			end
			default: begin
				a_sel = a_coords[0];
				b_sel = b_coords[0];
			end
		endcase
	end

	// b - a with borrow; borrow set means the end lies below the start
	assign diff     = {1'b0, b_sel} - {1'b0, a_sel};
	assign neg      = diff[COORD_BITS];
	assign abs_diff = neg ? (a_sel - b_sel) : diff[COORD_BITS-1:0];

endmodule

`default_nettype wire

// ===== rtl/line_point_generator_3d_unit.sv =====
// 3D Bresenham line generator: emits every voxel from start to end point.
// After an input beat is taken, the sequencer works out the three axis deltas one axis
// at a time through one shared subtractor (ST_DELTA), picks the major axis (ST_MAJOR),
// then emits one point per cycle from the step logic while out_stall is low (ST_RUN);
// in_stall holds off a new line until the last point of the current one is taken.
// Reset (arst_n low, asynchronous): sequencer idle, no point pending.
`default_nettype none

module line_point_generator_3d_unit #(
	parameter int COORD_BITS = 6
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire [COORD_BITS-1:0]  start_x,
	input  wire [COORD_BITS-1:0]  start_y,
	input  wire [COORD_BITS-1:0]  start_z,
	input  wire [COORD_BITS-1:0]  end_x,
	input  wire [COORD_BITS-1:0]  end_y,
	input  wire [COORD_BITS-1:0]  end_z,
	output logic                  out_valid,
	input  wire                   out_stall,
	output logic [COORD_BITS-1:0] point_x,
	output logic [COORD_BITS-1:0] point_y,
	output logic [COORD_BITS-1:0] point_z,
	output logic                  last_point
);

	// error stays in [-M, M) and error plus step in [-M, 3M), with M < 2^COORD_BITS
	localparam int EW = COORD_BITS + 3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DELTA,
		ST_MAJOR,
		ST_RUN
	} state_t;

	state_t                      state_q;
	l3d_pkg::axis_t              ax_q;
	l3d_pkg::axis_t              major_q;
	l3d_pkg::axis_t              major_d;
	logic [2:0][COORD_BITS-1:0]  pos_q;
	logic [2:0][COORD_BITS-1:0]  fin_q;
	logic [2:0][COORD_BITS-1:0]  dlt_q;
	logic [2:0]                  neg_q;
	logic [2:0][EW-1:0]          err_q;
	logic [2:0][EW-1:0]          err_d;
	logic [2:0][COORD_BITS-1:0]  pos_d;
	logic [COORD_BITS-1:0]       m_q;
	logic [COORD_BITS-1:0]       m_d;
	logic [COORD_BITS-1:0]       rem_q;
	logic [COORD_BITS-1:0]       diff_abs;
	logic                        diff_neg;
	logic                        out_take;

	l3d_axis_diff #(
		.COORD_BITS(COORD_BITS)
	) u_diff (
		.a_coords (pos_q),
		.b_coords (fin_q),
		.sel      (ax_q),
		.abs_diff (diff_abs),
		.neg      (diff_neg)
	);

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = (state_q == ST_RUN);
	assign out_take   = out_valid && !out_stall;
	assign point_x    = pos_q[0];
	assign point_y    = pos_q[1];
	assign point_z    = pos_q[2];
	assign last_point = (rem_q == '0);

	// driving axis: ties go to the lower axis
	always_comb begin
		major_d = l3d_pkg::AXIS_X;
		m_d     = dlt_q[0];
		if (dlt_q[1] > m_d) begin
			major_d = l3d_pkg::AXIS_Y;
			m_d     = dlt_q[1];
		end
		if (dlt_q[2] > m_d) begin
			major_d = l3d_pkg::AXIS_Z;
			m_d     = dlt_q[2];
		end
	end

	// next point: major axis always moves, minor axes move once error reaches M
	always_comb begin
		logic [EW-1:0] sum;
		logic [EW-1:0] m_ext;
		logic [EW-1:0] m_twice;
		logic          mv;
		m_ext   = EW'(m_q);
		m_twice = EW'({m_q, 1'b0});
		for (int a = 0; a < 3; a++) begin
			sum = err_q[a] + EW'({dlt_q[a], 1'b0});
			if (major_q == l3d_pkg::axis_t'(2'(a))) begin
				mv       = 1'b1;
				err_d[a] = err_q[a];
			end else if ($signed(sum) >= $signed(m_ext)) begin
				mv       = 1'b1;
				err_d[a] = sum - m_twice;
			end else begin
				mv       = 1'b0;
				err_d[a] = sum;
			end
			if (!mv)
				pos_d[a] = pos_q[a];
			else if (neg_q[a])
				pos_d[a] = pos_q[a] - COORD_BITS'(1);
			else
				pos_d[a] = pos_q[a] + COORD_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ax_q    <= l3d_pkg::AXIS_X;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DELTA;
						ax_q    <= l3d_pkg::AXIS_X;
					end
				end
				ST_DELTA: begin
					case (ax_q)
						l3d_pkg::AXIS_X: ax_q <= l3d_pkg::AXIS_Y;
						l3d_pkg::AXIS_Y: ax_q <= l3d_pkg::AXIS_Z;
						default: begin
							ax_q    <= l3d_pkg::AXIS_X;
							state_q <= ST_MAJOR;
						end
					endcase
				end
				ST_MAJOR: begin
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (out_take && last_point)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					pos_q <= {start_z, start_y, start_x};
					fin_q <= {end_z, end_y, end_x};
				end
			end
			ST_DELTA: begin
				dlt_q[ax_q] <= diff_abs;
				neg_q[ax_q] <= diff_neg;
			end
			ST_MAJOR: begin
				major_q <= major_d;
				m_q     <= m_d;
				rem_q   <= m_d;
				err_q   <= '0;
			end
			ST_RUN: begin
				if (out_take && !last_point) begin
					pos_q <= pos_d;
					err_q <= err_d;
					rem_q <= rem_q - COORD_BITS'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sim/line_voxel_checker.sv =====
// Watches both channels of line_point_generator_3d_unit, predicts each voxel of
// every accepted line and compares the points that come out. Uses l3d_pkg.
`default_nettype none

module line_voxel_checker #(
	parameter int CB = 6
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          in_valid,
	input  wire          in_stall,
	input  wire [CB-1:0] start_x,
	input  wire [CB-1:0] start_y,
	input  wire [CB-1:0] start_z,
	input  wire [CB-1:0] end_x,
	input  wire [CB-1:0] end_y,
	input  wire [CB-1:0] end_z,
	input  wire          out_valid,
	input  wire          out_stall,
	input  wire [CB-1:0] point_x,
	input  wire [CB-1:0] point_y,
	input  wire [CB-1:0] point_z,
	input  wire          last_point,
	output int           mismatches,
	output int           due_count
);

	typedef struct {
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic [CB-1:0] z;
		logic          last;
	} voxel_t;

	voxel_t due_voxels[$];
	voxel_t want;

	// Bresenham walk with integer error scaled by twice the driving delta
	task automatic trace_line(input logic [CB-1:0] sx, sy, sz, ex, ey, ez);
		int cur[3];
		int tgt[3];
		int span[3];
		int stepdir[3];
		int acc[3];
		l3d_pkg::axis_t drive;
		int run;
		voxel_t v;
		cur[0] = sx; cur[1] = sy; cur[2] = sz;
		tgt[0] = ex; tgt[1] = ey; tgt[2] = ez;
		for (int a = 0; a < 3; a++) begin
			span[a] = (tgt[a] > cur[a]) ? tgt[a] - cur[a] : cur[a] - tgt[a];
			stepdir[a] = (tgt[a] > cur[a]) ? 1 : ((tgt[a] < cur[a]) ? -1 : 0);
			acc[a] = 0;
		end
		// ties keep the earlier axis
		drive = l3d_pkg::AXIS_X;
		if (span[l3d_pkg::AXIS_Y] > span[drive]) drive = l3d_pkg::AXIS_Y;
		if (span[l3d_pkg::AXIS_Z] > span[drive]) drive = l3d_pkg::AXIS_Z;
		run = span[drive];
		for (int i = 0; i <= run; i++) begin
			v.x = CB'(cur[0]);
			v.y = CB'(cur[1]);
			v.z = CB'(cur[2]);
			v.last = (i == run);
			due_voxels.push_back(v);
			if (i < run) begin
				for (int a = 0; a < 3; a++) begin
					if (l3d_pkg::axis_t'(a) == drive) begin
						cur[a] += stepdir[a];
					end else begin
						acc[a] += 2 * span[a];
						if (acc[a] >= run) begin
							cur[a] += stepdir[a];
							acc[a] -= 2 * run;
						end
					end
				end
			end
		end
	endtask

	task automatic check_field(input string label, input int exp_val, input int got_val);
		if (exp_val != got_val) begin
			mismatches++;
			$display("%0t: %s expected %0d, actual %0d", $time, label, exp_val, got_val);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				trace_line(start_x, start_y, start_z, end_x, end_y, end_z);
			if (out_valid && !out_stall) begin
				if (due_voxels.size() == 0) begin
					mismatches++;
					$display("%0t: point (%0d,%0d,%0d) last %0b expected none", $time,
						point_x, point_y, point_z, last_point);
				end else begin
					want = due_voxels.pop_front();
					check_field("point_x", want.x, point_x);
					check_field("point_y", want.y, point_y);
					check_field("point_z", want.z, point_z);
					check_field("last_point", want.last, last_point);
				end
			end
		end
		due_count = due_voxels.size();
	end

endmodule

`default_nettype wire

// ===== sim/line_point_generator_3d_unit_test.sv =====
// Top of the line_point_generator_3d_unit bench: clock, reset and line stimulus
// with random idling on both sides. Needs line_voxel_checker and l3d_pkg.
`default_nettype none

module line_point_generator_3d_unit_test;
	localparam int CB = 6;
	localparam int TOP = (1 << CB) - 1;
	localparam int LINE_COUNT = 380;
	localparam int HOLD_CYCLES = 300;

	typedef logic [CB-1:0] coord_t;

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_stall;
	coord_t start_x, start_y, start_z, end_x, end_y, end_z;
	logic   out_valid;
	logic   out_stall;
	coord_t point_x, point_y, point_z;
	logic   last_point;

	int mismatches;
	int due_count;
	int gap_pct;
	int stall_pct;
	bit hold_req;
	bit hold_done;

	line_point_generator_3d_unit #(.COORD_BITS(CB)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.start_x(start_x), .start_y(start_y), .start_z(start_z),
		.end_x(end_x), .end_y(end_y), .end_z(end_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.last_point(last_point)
	);

	line_voxel_checker #(.CB(CB)) watch (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.start_x(start_x), .start_y(start_y), .start_z(start_z),
		.end_x(end_x), .end_y(end_y), .end_z(end_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.last_point(last_point),
		.mismatches(mismatches), .due_count(due_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// output side: short random stalls, or one long hold-off on request
	initial begin
		out_stall = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall = 1'b0;
				hold_done = 1'b1;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 3)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	initial begin
		#(8 * 600000);
		$display("status: fail");
		$finish;
	end

	// one beat; valid stays up between back-to-back lines
	task automatic offer_line(input int sx, sy, sz, ex, ey, ez);
		int idle;
		@(negedge clk);
		if ($urandom_range(0, 99) < gap_pct) begin
			idle = $urandom_range(1, 3);
			in_valid = 1'b0;
			repeat (idle) @(negedge clk);
		end
		start_x = coord_t'(sx);
		start_y = coord_t'(sy);
		start_z = coord_t'(sz);
		end_x = coord_t'(ex);
		end_y = coord_t'(ey);
		end_z = coord_t'(ez);
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic int clamp_coord(input int v);
		return (v < 0) ? 0 : ((v > TOP) ? TOP : v);
	endfunction

	// mostly short lines; some with endpoints anywhere in the cube, a few of zero length
	task automatic offer_random_line();
		int s[3];
		int e[3];
		int style;
		style = $urandom_range(0, 9);
		for (int a = 0; a < 3; a++) begin
			s[a] = $urandom_range(0, TOP);
			if (style == 0)
				e[a] = s[a];
			else if (style <= 3)
				e[a] = $urandom_range(0, TOP);
			else
				e[a] = clamp_coord(s[a] + int'($urandom_range(0, 14)) - 7);
		end
		offer_line(s[0], s[1], s[2], e[0], e[1], e[2]);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		start_x = '0; start_y = '0; start_z = '0;
		end_x = '0; end_y = '0; end_z = '0;
		gap_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		gap_pct = 25;
		stall_pct = 25;
		offer_line(0, 0, 0, 0, 0, 0);
		offer_line(TOP, TOP, TOP, TOP, TOP, TOP);
		offer_line(0, 0, 0, TOP, TOP, TOP);
		offer_line(TOP, TOP, TOP, 0, 0, 0);
		offer_line(0, 5, 9, TOP, 5, 9);
		offer_line(TOP, 5, 9, 0, 5, 9);
		offer_line(7, 0, 3, 7, TOP, 3);
		offer_line(7, TOP, 3, 7, 0, 3);
		offer_line(1, 2, 0, 1, 2, TOP);
		offer_line(1, 2, TOP, 1, 2, 0);
		offer_line(10, 10, 10, 30, 30, 12);
		offer_line(10, 10, 10, 12, 30, 30);
		offer_line(10, 10, 10, 30, 12, 30);
		offer_line(0, TOP, 0, TOP, 0, TOP);
		offer_line(5, 0, 40, 20, TOP, 33);
		offer_line(50, 20, 0, 40, 22, TOP);
		offer_line(0, 0, 0, TOP, 1, 31);
		offer_line(32, 32, 32, 33, 32, 31);
		offer_line(TOP, 0, TOP, 0, 62, 1);
		offer_line(21, 42, 21, 42, 21, 42);

		for (int n = 0; n < LINE_COUNT; n++) begin
			if (n == 100) begin
				gap_pct = 0;
				stall_pct = 0;
			end else if (n == 140) begin
				gap_pct = 30;
				stall_pct = 30;
			end else if (n == LINE_COUNT - 60) begin
				gap_pct = 0;
				stall_pct = 0;
			end
			// receiver holds off while lines keep coming
			if (n == 160)
				hold_req = 1'b1;
			offer_random_line();
		end
		@(negedge clk);
		in_valid = 1'b0;

		while (due_count != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/l3d_pkg.sv
rtl/l3d_axis_diff.sv
rtl/line_point_generator_3d_unit.sv
sim/line_voxel_checker.sv
sim/line_point_generator_3d_unit_test.sv
